[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk_i, held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

[hdl/csvt_pkg.sv]
// ---------------------------------------------------------------------------
// csvt_pkg
// Byte constants, status codes and the front-to-back command type.
// ---------------------------------------------------------------------------
package csvt_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] DELIM_RESET = 8'h2C;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_JUNK     = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTRW  = 2;

  // One command per accepted item that does anything visible.
  typedef struct packed {
    logic       flush;      // emit held whitespace first
    logic [1:0] flush_st;   // status on flushed bytes
    logic       clear;      // drop held whitespace
    logic       push;       // hold one whitespace byte
    logic       push_tab;   // held byte is a tab
    logic       emit;       // emit the result below (always last of the item)
    logic [7:0] tbyte;
    logic       bvalid;
    logic       tend;
    logic       eol;
    logic       eof;
    logic [1:0] status;
  } cmd_t;

endpackage

[hdl/csvt_front.sv]
// ---------------------------------------------------------------------------
// csvt_front
// Accepts bytes, tracks the field mode and issues commands to the back end.
// ---------------------------------------------------------------------------
module csvt_front #(
  parameter int unsigned PENDING_WS_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            acc_i,       // input beat accepted
  input  logic            req_type_i,
  input  logic [7:0]      data_byte_i,
  output logic            cmd_valid_o,
  output csvt_pkg::cmd_t  cmd_o
);

  localparam int unsigned CW = $clog2(PENDING_WS_DEPTH + 1);

  localparam logic [1:0] MODE_LEAD   = 2'd0;
  localparam logic [1:0] MODE_PLAIN  = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_AFTERQ = 2'd3;

  logic [7:0]    delim_q;
  logic [1:0]    mode_q, mode_d;
  logic          err_q, err_d;
  logic [CW-1:0] wscnt_q, wscnt_d;

  logic is_ws, is_nl, is_dl, is_qt, is_end;

  assign is_ws  = (data_byte_i == csvt_pkg::CH_SPACE) || (data_byte_i == csvt_pkg::CH_TAB);
  assign is_nl  = (data_byte_i == csvt_pkg::CH_NL);
  assign is_dl  = (data_byte_i == delim_q);
  assign is_qt  = (data_byte_i == csvt_pkg::CH_QUOTE);
  assign is_end = is_dl || is_nl;

  always_comb begin
    csvt_pkg::cmd_t c;
    logic           cv;
    c        = '0;
    cv       = 1'b0;
    mode_d   = mode_q;
    err_d    = err_q;
    wscnt_d  = wscnt_q;
    if (acc_i && !err_q) begin
      if (req_type_i) begin
        // end of stream closes whatever is open
        cv      = 1'b1;
        c.clear = 1'b1;
        c.emit  = 1'b1;
        c.tend  = 1'b1;
        c.eof   = 1'b1;
        mode_d  = MODE_LEAD;
        wscnt_d = '0;
      end else begin
        unique case (mode_q)
          MODE_LEAD: begin
            if (is_ws) begin
              mode_d = MODE_LEAD;
            end else if (is_qt) begin
              mode_d = MODE_QUOTED;
            end else if (is_end) begin
              cv     = 1'b1;
              c.emit = 1'b1;
              c.tend = 1'b1;
              c.eol  = is_nl;
            end else begin
              cv       = 1'b1;
              c.emit   = 1'b1;
              c.tbyte  = data_byte_i;
              c.bvalid = 1'b1;
              mode_d   = MODE_PLAIN;
            end
          end
          MODE_PLAIN: begin
            if (is_end) begin
              cv      = 1'b1;
              c.clear = 1'b1;
              c.emit  = 1'b1;
              c.tend  = 1'b1;
              c.eol   = is_nl;
              mode_d  = MODE_LEAD;
              wscnt_d = '0;
            end else if (is_ws) begin
              cv         = 1'b1;
              c.push     = 1'b1;
              c.push_tab = (data_byte_i == csvt_pkg::CH_TAB);
              if (wscnt_q == CW'(PENDING_WS_DEPTH)) begin
                // buffer full: spill it with overflow status, then hold
                c.flush    = 1'b1;
                c.flush_st = csvt_pkg::ST_OVERFLOW;
                wscnt_d    = CW'(1);
              end else begin
                wscnt_d = wscnt_q + CW'(1);
              end
            end else begin
              cv         = 1'b1;
              c.flush    = 1'b1;
              c.flush_st = csvt_pkg::ST_OK;
              c.emit     = 1'b1;
              c.tbyte    = data_byte_i;
              c.bvalid   = 1'b1;
              wscnt_d    = '0;
            end
          end
          MODE_QUOTED: begin
            if (is_qt) begin
              mode_d = MODE_AFTERQ;
            end else begin
              cv       = 1'b1;
              c.emit   = 1'b1;
              c.tbyte  = data_byte_i;
              c.bvalid = 1'b1;
            end
          end
          MODE_AFTERQ: begin
            if (is_end) begin
              cv     = 1'b1;
              c.emit = 1'b1;
              c.tend = 1'b1;
              c.eol  = is_nl;
              mode_d = MODE_LEAD;
            end else if (!is_ws) begin
              cv       = 1'b1;
              c.emit   = 1'b1;
              c.status = csvt_pkg::ST_JUNK;
              err_d    = 1'b1;
            end
          end
          default: mode_d = MODE_LEAD;
        endcase
      end
    end
    cmd_o       = c;
    cmd_valid_o = cv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= csvt_pkg::DELIM_RESET;
      mode_q  <= MODE_LEAD;
      err_q   <= 1'b0;
      wscnt_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        delim_q <= cfg_data_i;
      end
      mode_q  <= mode_d;
      err_q   <= err_d;
      wscnt_q <= wscnt_d;
    end
  end

endmodule

[hdl/csvt_cmd_fifo.sv]
// ---------------------------------------------------------------------------
// csvt_cmd_fifo
// Small command queue between front and back end.
// ---------------------------------------------------------------------------
module csvt_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  csvt_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output csvt_pkg::cmd_t  head_o
);

  localparam int unsigned PW   = csvt_pkg::QPTRW;
  localparam int unsigned CNTW = csvt_pkg::QPTRW + 1;

  csvt_pkg::cmd_t               mem_q [csvt_pkg::QDEPTH];
  logic [csvt_pkg::QPTRW-1:0]   wptr_q, rptr_q;
  logic [CNTW-1:0]              cnt_q;
  logic                         do_push, do_pop;

  assign full_o       = (cnt_q == CNTW'(csvt_pkg::QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

endmodule

[hdl/csvt_back.sv]
// ---------------------------------------------------------------------------
// csvt_back
// Executes commands: holds trailing whitespace, flushes it, drives results.
// ---------------------------------------------------------------------------
module csvt_back #(
  parameter int unsigned PENDING_WS_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  csvt_pkg::cmd_t  head_i,
  output logic            pop_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [7:0]      token_byte_o,
  output logic            byte_valid_o,
  output logic            token_end_o,
  output logic            end_of_line_o,
  output logic            end_of_file_o,
  output logic [1:0]      status_o,
  output logic            last_o
);

  localparam int unsigned CW   = $clog2(PENDING_WS_DEPTH + 1);
  localparam int unsigned IDXW = (PENDING_WS_DEPTH > 1) ? $clog2(PENDING_WS_DEPTH) : 1;

  // held whitespace, entry 0 oldest; 1 = tab
  logic [PENDING_WS_DEPTH-1:0] ws_q, ws_d;
  logic [CW-1:0]               cnt_q, cnt_d;

  logic       ov_q, ov_d;
  logic [7:0] ob_q, ob_d;
  logic       obv_q, obv_d, oend_q, oend_d, oeol_q, oeol_d, oeof_q, oeof_d;
  logic [1:0] ost_q, ost_d;
  logic       olast_q, olast_d;

  logic room, go, flushing;

  assign room     = !ov_q || !out_stall_i;
  assign go       = head_valid_i && room;
  assign flushing = head_i.flush && (cnt_q != '0);
  assign pop_o    = go && !flushing;

  always_comb begin
    ws_d    = ws_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && out_stall_i;
    ob_d    = ob_q;
    obv_d   = obv_q;
    oend_d  = oend_q;
    oeol_d  = oeol_q;
    oeof_d  = oeof_q;
    ost_d   = ost_q;
    olast_d = olast_q;
    if (go) begin
      if (flushing) begin
        ov_d    = 1'b1;
        ob_d    = ws_q[0] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
        obv_d   = 1'b1;
        oend_d  = 1'b0;
        oeol_d  = 1'b0;
        oeof_d  = 1'b0;
        ost_d   = head_i.flush_st;
        olast_d = !head_i.emit && (cnt_q == CW'(1));
        ws_d    = ws_q >> 1;
        cnt_d   = cnt_q - CW'(1);
      end else begin
        if (head_i.emit) begin
          ov_d    = 1'b1;
          ob_d    = head_i.tbyte;
          obv_d   = head_i.bvalid;
          oend_d  = head_i.tend;
          oeol_d  = head_i.eol;
          oeof_d  = head_i.eof;
          ost_d   = head_i.status;
          olast_d = 1'b1;
        end
        if (head_i.clear) begin
          cnt_d = '0;
        end else if (head_i.push) begin
          ws_d[cnt_q[IDXW-1:0]] = head_i.push_tab;
          cnt_d = cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ws_q    <= ws_d;
    ob_q    <= ob_d;
    obv_q   <= obv_d;
    oend_q  <= oend_d;
    oeol_q  <= oeol_d;
    oeof_q  <= oeof_d;
    ost_q   <= ost_d;
    olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  assign out_valid_o   = ov_q;
  assign token_byte_o  = ob_q;
  assign byte_valid_o  = obv_q;
  assign token_end_o   = oend_q;
  assign end_of_line_o = oeol_q;
  assign end_of_file_o = oeof_q;
  assign status_o      = ost_q;
  assign last_o        = olast_q;

endmodule

[hdl/csv_field_tokenizer.sv]
// ---------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV field tokenizer: bytes in, field bytes and token ends out.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one beat is a raw byte
//    (req_type_i = 0) or an end-of-stream marker (req_type_i = 1).
//  - Output channel (out_valid_o / out_stall_i): one beat is a field byte,
//    a token end (with end_of_line / end_of_file), or a junk-error note.
//    last_o marks the final beat caused by one input beat.
//  - Config channel (cfg_valid_i / cfg_ready_o): writes the delimiter byte;
//    always ready. Write only while the block is idle.
//  - Throughput: one input byte per cycle. A byte that releases held
//    whitespace costs one extra output beat per held space or tab; the
//    back end spends those beats while the front keeps accepting until
//    the four-entry command queue fills.
//  - An accepted byte passes through the queue register, then the output
//    register, on the way to its first output beat.
//  - Reset clears mode, error flag, held whitespace and the queue; the
//    delimiter returns to comma. No clearing pass is needed.
//  - Receiver stall holds the output register; the back end waits, the
//    queue fills, and then in_stall_o rises.
module csv_field_tokenizer #(
  parameter int unsigned PENDING_WS_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // input beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] data_byte_i,
  // output beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] token_byte_o,
  output logic       byte_valid_o,
  output logic       token_end_o,
  output logic       end_of_line_o,
  output logic       end_of_file_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic           q_full, acc;
  logic           cmd_valid;
  csvt_pkg::cmd_t cmd;
  logic           head_valid, pop;
  csvt_pkg::cmd_t head;

  // each input beat makes at most one command, so a free slot is enough
  assign in_stall_o  = q_full;
  assign acc         = in_valid_i && !q_full;
  assign cfg_ready_o = 1'b1;

  csvt_front #(
    .PENDING_WS_DEPTH(PENDING_WS_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .acc_i       (acc),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  csvt_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_valid),
    .push_cmd_i   (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  csvt_back #(
    .PENDING_WS_DEPTH(PENDING_WS_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .token_byte_o  (token_byte_o),
    .byte_valid_o  (byte_valid_o),
    .token_end_o   (token_end_o),
    .end_of_line_o (end_of_line_o),
    .end_of_file_o (end_of_file_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

[hdl/csvt_checker.sv]
// ---------------------------------------------------------------------------
// csvt_checker
// Port-level checks on the tokenizer's result beats.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module csvt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] token_byte_o,
  input logic       byte_valid_o,
  input logic       token_end_o,
  input logic       end_of_line_o,
  input logic       end_of_file_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  logic        held;
  logic [14:0] payload;
  logic        flags_set;
  logic        junk_beat;
  logic        junk_shape;

  assign held       = out_valid_o && out_stall_i;
  assign payload    = {token_byte_o, byte_valid_o, token_end_o, end_of_line_o,
                       end_of_file_o, status_o, last_o};
  assign flags_set  = end_of_line_o || end_of_file_o;
  assign junk_beat  = out_valid_o && (status_o == csvt_pkg::ST_JUNK);
  assign junk_shape = !byte_valid_o && !token_end_o && last_o;

  `ASSERT_CLK(a_stall_hold, held |=> (out_valid_o && $stable(payload)), "stalled beat changed")
  `ASSERT_NEVER(a_byte_and_end, out_valid_o && byte_valid_o && token_end_o, "byte with token end")
  `ASSERT_NEVER(a_flags_need_end, out_valid_o && !token_end_o && flags_set, "flag without end")
  `ASSERT_CLK(a_junk_beat, junk_beat |-> junk_shape, "junk beat malformed")

endmodule

bind csv_field_tokenizer csvt_checker u_csvt_checker (.*);

[sim/csv_field_tokenizer_test.sv]
// ---------------------------------------------------------------------------
// csv_field_tokenizer_test
// Self-checking bench for the CSV field tokenizer. Byte and end-of-stream
// beats go in through the stall handshake. A model in the bench works
// out the field bytes and token ends that each accepted beat causes. Every
// output beat is compared field by field with the oldest expected one.
// Directed cases cover whitespace trim, quoted fields, end of stream,
// whitespace overflow, one long receiver hold-off and the sticky junk
// error. Mostly well-formed random records then run under a sweep of
// delimiter values, with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module csv_field_tokenizer_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WS_DEPTH    = 16;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on any channel
  localparam int DRAIN_WAIT  = 8;     // covers queue + output register
  localparam int PHASE_BEATS = 25;    // random beats per delimiter setting
  localparam int HOLD_OFF    = 200;   // long receiver stall

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // parser state as the bench tracks it
  typedef enum logic [1:0] {
    PM_LEAD,
    PM_PLAIN,
    PM_QUOTED,
    PM_AFTERQ
  } parse_mode_e;

  // one output beat, in port order
  typedef struct packed {
    logic [7:0] tok;
    logic       bv;
    logic       tend;
    logic       eol;
    logic       eof;
    logic [1:0] st;
    logic       last;
  } beat_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       req_type_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] token_byte_o;
  logic       byte_valid_o;
  logic       token_end_o;
  logic       end_of_line_o;
  logic       end_of_file_o;
  logic [1:0] status_o;
  logic       last_o;

  csv_field_tokenizer #(
    .PENDING_WS_DEPTH(WS_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .token_byte_o (token_byte_o),
    .byte_valid_o (byte_valid_o),
    .token_end_o  (token_end_o),
    .end_of_line_o(end_of_line_o),
    .end_of_file_o(end_of_file_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // bench copy of the tokenizer state
  logic [7:0]          delim;
  parse_mode_e         mode;
  logic [WS_DEPTH-1:0] held_tab;
  int                  held_cnt;
  logic                junk_seen;

  beat_t expected_tokens[$];

  int  mismatches;
  int  beats_in;
  int  beats_out;
  int  in_stall_cycles;
  int  delim_settings;
  bit  send_idle;
  bit  recv_idle;
  int  stall_left;
  int  hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // -------------------------------------------------------------------------
  // Prediction
  // -------------------------------------------------------------------------
  function automatic beat_t mk_beat(logic [7:0] tb, logic bv, logic te, logic el,
                                    logic ef, logic [1:0] st);
    beat_t r;
    r.tok  = bv ? tb : 8'h00;
    r.bv   = bv;
    r.tend = te;
    r.eol  = el;
    r.eof  = ef;
    r.st   = st;
    r.last = 1'b0;
    return r;
  endfunction

  // Works out the output beats of one accepted input beat and queues them.
  task automatic predict_tokens(input logic eos, input logic [7:0] b);
    beat_t      outs[$];
    logic       is_ws;
    logic       is_nl;
    logic       is_dl;
    logic       is_qt;
    logic [1:0] fst;
    logic [7:0] wsb;
    is_ws = (b == csvt_pkg::CH_SPACE) || (b == csvt_pkg::CH_TAB);
    is_nl = (b == csvt_pkg::CH_NL);
    is_dl = (b == delim);
    is_qt = (b == csvt_pkg::CH_QUOTE);
    if (junk_seen) return;  // sticky: nothing more until reset
    if (eos) begin
      // held whitespace dropped, even inside an open quote
      held_cnt = 0;
      mode = PM_LEAD;
      outs.push_back(mk_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b1, csvt_pkg::ST_OK));
    end else begin
      case (mode)
        PM_LEAD: begin
          // whitespace skip wins over quote, quote over delimiter
          if (is_ws) begin
          end else if (is_qt) begin
            mode = PM_QUOTED;
          end else if (is_dl || is_nl) begin
            outs.push_back(mk_beat(8'h00, 1'b0, 1'b1, is_nl, 1'b0, csvt_pkg::ST_OK));
          end else begin
            mode = PM_PLAIN;
            outs.push_back(mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0, csvt_pkg::ST_OK));
          end
        end
        PM_PLAIN: begin
          if (is_dl || is_nl) begin
            held_cnt = 0;  // trailing whitespace trimmed
            mode = PM_LEAD;
            outs.push_back(mk_beat(8'h00, 1'b0, 1'b1, is_nl, 1'b0, csvt_pkg::ST_OK));
          end else begin
            // ordinary byte releases held whitespace; a full buffer
            // releases it with the overflow status
            if (!is_ws || held_cnt >= WS_DEPTH) begin
              fst = is_ws ? csvt_pkg::ST_OVERFLOW : csvt_pkg::ST_OK;
              for (int i = 0; i < held_cnt; i++) begin
                wsb = held_tab[i] ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
                outs.push_back(mk_beat(wsb, 1'b1, 1'b0, 1'b0, 1'b0, fst));
              end
              held_cnt = 0;
            end
            if (is_ws) begin
              held_tab[held_cnt] = (b == csvt_pkg::CH_TAB);
              held_cnt++;
            end else begin
              outs.push_back(mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0, csvt_pkg::ST_OK));
            end
          end
        end
        PM_QUOTED: begin
          if (is_qt) mode = PM_AFTERQ;
          else outs.push_back(mk_beat(b, 1'b1, 1'b0, 1'b0, 1'b0, csvt_pkg::ST_OK));
        end
        default: begin
          if (is_dl || is_nl) begin
            mode = PM_LEAD;
            outs.push_back(mk_beat(8'h00, 1'b0, 1'b1, is_nl, 1'b0, csvt_pkg::ST_OK));
          end else if (!is_ws) begin
            junk_seen = 1'b1;
            outs.push_back(mk_beat(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, csvt_pkg::ST_JUNK));
          end
        end
      endcase
    end
    if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
    foreach (outs[i]) expected_tokens.push_back(outs[i]);
  endtask

  // -------------------------------------------------------------------------
  // Drivers
  // -------------------------------------------------------------------------
  // One input beat: random gap, then hold until accepted, then predict.
  task automatic send_beat(input logic eos, input logic [7:0] b);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= eos;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    beats_in++;
    predict_tokens(eos, b);
  endtask

  // Random part never sends junk after a closing quote: that error is
  // sticky and would silence the rest of the run.
  function automatic logic [7:0] guard_byte(logic [7:0] b);
    if (mode == PM_AFTERQ &&
        !(b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB ||
          b == csvt_pkg::CH_NL || b == delim))
      return delim;
    return b;
  endfunction

  task automatic send_safe(input logic eos, input logic [7:0] b);
    send_beat(eos, eos ? b : guard_byte(b));
  endtask

  // Stop input, wait out every expected beat plus the pipeline latency
  // (held whitespace leaves nothing to wait for otherwise).
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_delimiter(input logic [7:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    delim = value;
    delim_settings++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] ws_byte();
    return $urandom_range(0, 1) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE;
  endfunction

  // byte that is plain content under the current delimiter
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB || b == csvt_pkg::CH_NL ||
           b == csvt_pkg::CH_QUOTE || b == delim);
    return b;
  endfunction

  function automatic logic [7:0] quoted_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0: return delim;
      1: return csvt_pkg::CH_NL;
      2: return ws_byte();
      default: begin
        do b = 8'($urandom); while (b == csvt_pkg::CH_QUOTE);
        return b;
      end
    endcase
  endfunction

  // One field with random content, then a terminator. Mostly well formed;
  // a tenth of the fields are raw noise.
  task automatic send_random_field();
    int kind;
    int pick;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) send_safe(REQ_BYTE, ws_byte());
    if (kind < 5) begin
      send_safe(REQ_BYTE, plain_byte());
      repeat ($urandom_range(0, 7)) begin
        pick = $urandom_range(0, 19);
        if (pick < 13) send_safe(REQ_BYTE, plain_byte());
        else if (pick < 18) repeat ($urandom_range(1, 3)) send_safe(REQ_BYTE, ws_byte());
        else if (pick == 18) repeat ($urandom_range(15, 20)) send_safe(REQ_BYTE, ws_byte());
        else send_safe(REQ_BYTE, csvt_pkg::CH_QUOTE);  // ordinary inside a plain field
      end
      repeat ($urandom_range(0, 3)) send_safe(REQ_BYTE, ws_byte());
    end else if (kind < 8) begin
      send_safe(REQ_BYTE, csvt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 8)) send_safe(REQ_BYTE, quoted_byte());
      send_safe(REQ_BYTE, csvt_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 2)) send_safe(REQ_BYTE, ws_byte());
    end else if (kind == 9) begin
      repeat ($urandom_range(1, 4))
        send_safe(($urandom_range(0, 9) == 0) ? REQ_EOS : REQ_BYTE, 8'($urandom));
    end
    // kind 8: empty field
    pick = $urandom_range(0, 19);
    if (pick < 11) send_safe(REQ_BYTE, delim);
    else if (pick < 18) send_safe(REQ_BYTE, csvt_pkg::CH_NL);
    else send_safe(REQ_EOS, 8'($urandom));
  endtask

  // -------------------------------------------------------------------------
  // Receiver: per-beat random stall, plus a long hold-off on request
  // -------------------------------------------------------------------------
  initial begin : receiver
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Checker
  // -------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_beats
    beat_t got;
    beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {token_byte_o, byte_valid_o, token_end_o, end_of_line_o, end_of_file_o,
             status_o, last_o};
      beats_out++;
      if (expected_tokens.size() == 0) begin
        report_mismatch("beat with nothing expected, token_byte", got.tok, 0);
      end else begin
        want = expected_tokens.pop_front();
        if (got.tok  !== want.tok)  report_mismatch("token_byte",  got.tok,  want.tok);
        if (got.bv   !== want.bv)   report_mismatch("byte_valid",  got.bv,   want.bv);
        if (got.tend !== want.tend) report_mismatch("token_end",   got.tend, want.tend);
        if (got.eol  !== want.eol)  report_mismatch("end_of_line", got.eol,  want.eol);
        if (got.eof  !== want.eof)  report_mismatch("end_of_file", got.eof,  want.eof);
        if (got.st   !== want.st)   report_mismatch("status",      got.st,   want.st);
        if (got.last !== want.last) report_mismatch("last",        got.last, want.last);
      end
      stall_left = recv_idle ? $urandom_range(0, 5) : 0;
    end
  end

  // Watchdog: run is stuck if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (in_valid_i && in_stall_o) in_stall_cycles++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat for %0d cycles, %0d still expected",
             IDLE_LIMIT, expected_tokens.size());
    $display("CHECK FAILED");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // leading whitespace skipped, inner whitespace kept, trailing trimmed
  task automatic test_whitespace_trim();
    send_beat(REQ_BYTE, csvt_pkg::CH_SPACE);
    send_beat(REQ_BYTE, "a");
    send_beat(REQ_BYTE, csvt_pkg::CH_TAB);
    send_beat(REQ_BYTE, "b");
    send_beat(REQ_BYTE, csvt_pkg::CH_SPACE);
    send_beat(REQ_BYTE, delim);
  endtask

  // empty field, then a quoted field with byte extremes and a literal
  // delimiter and newline, whitespace after the closing quote, end by newline
  task automatic test_quoted_field();
    send_beat(REQ_BYTE, delim);
    send_beat(REQ_BYTE, csvt_pkg::CH_QUOTE);
    send_beat(REQ_BYTE, 8'h00);
    send_beat(REQ_BYTE, 8'hFF);
    send_beat(REQ_BYTE, delim);
    send_beat(REQ_BYTE, csvt_pkg::CH_NL);
    send_beat(REQ_BYTE, csvt_pkg::CH_QUOTE);
    send_beat(REQ_BYTE, csvt_pkg::CH_SPACE);
    send_beat(REQ_BYTE, csvt_pkg::CH_NL);
  endtask

  // unclosed quote cut by end of stream, then a repeated end-of-stream marker
  task automatic test_end_of_stream();
    send_beat(REQ_BYTE, csvt_pkg::CH_QUOTE);
    send_beat(REQ_BYTE, "x");
    send_beat(REQ_BYTE, csvt_pkg::CH_SPACE);
    send_beat(REQ_EOS, 8'hFF);
    send_beat(REQ_EOS, 8'h00);
  endtask

  // one more held space or tab than the buffer holds
  task automatic test_whitespace_overflow();
    send_beat(REQ_BYTE, "a");
    for (int i = 0; i <= WS_DEPTH; i++)
      send_beat(REQ_BYTE, (i % 3 == 1) ? csvt_pkg::CH_TAB : csvt_pkg::CH_SPACE);
    send_beat(REQ_BYTE, "b");
    send_beat(REQ_BYTE, delim);
  endtask

  // receiver holds off while the sender streams with no gaps: the queue
  // fills and the input stalls
  task automatic test_output_backpressure();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    send_beat(REQ_BYTE, plain_byte());
    hold_cycles = HOLD_OFF;
    repeat (PHASE_BEATS) begin
      if ($urandom_range(0, 4) == 0) send_beat(REQ_BYTE, ws_byte());
      else send_beat(REQ_BYTE, plain_byte());
    end
    send_beat(REQ_BYTE, csvt_pkg::CH_NL);
    send_idle = 1'b1;
  endtask

  // random records under several delimiters, extremes and whitespace,
  // quote and newline collisions among them; ends back on comma
  task automatic test_delimiter_sweep();
    logic [7:0] sweep[8];
    int         start;
    sweep = '{8'h00, 8'hFF, csvt_pkg::CH_TAB, csvt_pkg::CH_SPACE, csvt_pkg::CH_QUOTE,
              csvt_pkg::CH_NL, 8'($urandom), csvt_pkg::DELIM_RESET};
    foreach (sweep[p]) begin
      write_delimiter(sweep[p]);
      send_idle = (p % 3 != 1);
      recv_idle = (p % 3 != 2);
      start = beats_in;
      while (beats_in - start < PHASE_BEATS) send_random_field();
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // junk after a closing quote latches the error; nothing follows it.
  // Must run last: only reset clears the latch.
  task automatic test_junk_after_quote();
    send_beat(REQ_EOS, 8'h00);
    send_beat(REQ_BYTE, csvt_pkg::CH_QUOTE);
    send_beat(REQ_BYTE, "x");
    send_beat(REQ_BYTE, csvt_pkg::CH_QUOTE);
    send_beat(REQ_BYTE, "z");
    send_beat(REQ_BYTE, "q");
    send_beat(REQ_EOS, 8'h00);
    send_beat(REQ_BYTE, delim);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_BYTE;
    data_byte_i = 8'h00;
    delim       = csvt_pkg::DELIM_RESET;
    mode        = PM_LEAD;
    held_tab    = '0;
    held_cnt    = 0;
    junk_seen   = 1'b0;
    mismatches  = 0;
    beats_in    = 0;
    beats_out   = 0;
    in_stall_cycles = 0;
    delim_settings  = 0;
    send_idle   = 1'b1;
    recv_idle   = 1'b1;
    stall_left  = 0;
    hold_cycles = 0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_whitespace_trim();
    test_quoted_field();
    test_end_of_stream();
    test_whitespace_overflow();
    test_output_backpressure();
    test_delimiter_sweep();
    test_junk_after_quote();

    wait_idle();
    repeat (4) @(posedge clk_i);

    $display("Ran %0d input beats and %0d output beats over %0d delimiter writes.",
             beats_in, beats_out, delim_settings);
    $display("Input held by backpressure %0d cycles; junk latch tested at the end.",
             in_stall_cycles);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[csv_field_tokenizer.f]
+incdir+hdl
hdl/csvt_pkg.sv
hdl/csvt_front.sv
hdl/csvt_cmd_fifo.sv
hdl/csvt_back.sv
hdl/csv_field_tokenizer.sv
hdl/csvt_checker.sv
sim/csv_field_tokenizer_test.sv
